[hdl/qts_pkg.sv]
// Shared types and constants for the quoted token splitter.
// No dependencies; imported by every module of the block.
`default_nettype none
package qts_pkg;

  localparam int MAX_RESULTS = 3;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_QUOTE   = 8'd34;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [4:0] num;
    logic       last;
  } result_t;

  typedef result_t [MAX_RESULTS-1:0] result_set_t;

  typedef logic [1:0] result_count_t;

endpackage
`default_nettype wire

[hdl/qts_step.sv]
// Per-character scanner: holds the line state and forms the results of one word.
// Depends on qts_pkg.
`default_nettype none
module qts_step #(
  parameter int MAX_TOKENS    = 16,
  parameter int MAX_TOKEN_LEN = 32,
  parameter int MAX_LINE_LEN  = 256
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire  [7:0]             char_value,
  input  wire                    fire,
  output qts_pkg::result_set_t   results,
  output qts_pkg::result_count_t count
);
  import qts_pkg::*;

  localparam int LW = (MAX_TOKEN_LEN > 2) ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int TW = $clog2(MAX_TOKENS + 1);
  localparam int PW = (MAX_LINE_LEN > 2) ? $clog2(MAX_LINE_LEN) : 1;
  localparam logic [LW-1:0] LEN_LIMIT  = LW'(MAX_TOKEN_LEN - 1);
  localparam logic [TW-1:0] TOK_LIMIT  = TW'(MAX_TOKENS);
  localparam logic [PW-1:0] LINE_LIMIT = PW'(MAX_LINE_LEN - 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PLAIN,
    MODE_QUOTE,
    MODE_DRAIN
  } mode_t;

  mode_t         scan_mode, scan_mode_next;
  logic [LW-1:0] token_length, token_length_next;
  logic [TW-1:0] token_total, token_total_next;
  logic [PW-1:0] line_position, line_position_next;

  always_comb begin
    logic is_term;
    logic is_sep;
    logic do_store;
    logic do_close;
    result_count_t n;
    is_term = (char_value == CHAR_NEWLINE) || (char_value == CHAR_NUL);
    is_sep = (char_value == CHAR_SPACE) || (char_value == CHAR_TAB);
    do_store = 1'b0;
    do_close = 1'b0;
    n = '0;
    results = '0;
    scan_mode_next = scan_mode;
    token_length_next = token_length;
    token_total_next = token_total;
    line_position_next = line_position;

    if (scan_mode == MODE_DRAIN) begin
      if (is_term) begin
        scan_mode_next = MODE_IDLE;
        token_length_next = '0;
        token_total_next = '0;
        line_position_next = '0;
      end
    end else if (is_term) begin
      if (scan_mode != MODE_IDLE) begin
        results[n] = '{kind: KIND_TOKEN_END, ch: 8'd0, num: 5'(token_total_next), last: 1'b0};
        n = n + 2'd1;
        token_total_next = token_total_next + 1'b1;
      end
      results[n] = '{kind: KIND_LINE_END, ch: 8'd0, num: 5'(token_total_next), last: 1'b0};
      n = n + 2'd1;
      scan_mode_next = MODE_IDLE;
      token_length_next = '0;
      token_total_next = '0;
      line_position_next = '0;
    end else begin
      line_position_next = line_position + 1'b1;
      case (scan_mode)
        MODE_IDLE: begin
          if (!is_sep) begin
            do_store = 1'b1;
            scan_mode_next = (char_value == CHAR_QUOTE) ? MODE_QUOTE : MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          if (is_sep) do_close = 1'b1;
          else do_store = 1'b1;
        end
        default: begin
          if (char_value == CHAR_QUOTE) begin
            do_store = 1'b1;
            do_close = 1'b1;
          end else if (char_value == CHAR_TAB) begin
            do_close = 1'b1;
          end else begin
            do_store = 1'b1;
          end
        end
      endcase

      if (do_store) begin
        results[n] = '{kind: KIND_CHAR, ch: char_value, num: 5'(token_total_next), last: 1'b0};
        n = n + 2'd1;
        token_length_next = token_length_next + 1'b1;
        if (token_length_next >= LEN_LIMIT) begin
          results[n] = '{kind: KIND_TOKEN_END, ch: 8'd0, num: 5'(token_total_next),
                         last: 1'b0};
          n = n + 2'd1;
          token_total_next = token_total_next + 1'b1;
          token_length_next = '0;
          scan_mode_next = MODE_IDLE;
        end
      end

      if (do_close && (scan_mode_next != MODE_IDLE)) begin
        results[n] = '{kind: KIND_TOKEN_END, ch: 8'd0, num: 5'(token_total_next), last: 1'b0};
        n = n + 2'd1;
        token_total_next = token_total_next + 1'b1;
        token_length_next = '0;
        scan_mode_next = MODE_IDLE;
      end

      if ((token_total_next >= TOK_LIMIT) || (line_position_next >= LINE_LIMIT)) begin
        if (scan_mode_next != MODE_IDLE) begin
          results[n] = '{kind: KIND_TOKEN_END, ch: 8'd0, num: 5'(token_total_next),
                         last: 1'b0};
          n = n + 2'd1;
          token_total_next = token_total_next + 1'b1;
        end
        results[n] = '{kind: KIND_LINE_END, ch: 8'd0, num: 5'(token_total_next), last: 1'b0};
        n = n + 2'd1;
        scan_mode_next = MODE_DRAIN;
        token_length_next = '0;
        token_total_next = '0;
        line_position_next = '0;
      end
    end

    if (n != 2'd0) begin
      results[n - 2'd1].last = 1'b1;
    end
    count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      token_length <= '0;
      token_total <= '0;
      line_position <= '0;
    end else if (fire) begin
      scan_mode <= scan_mode_next;
      token_length <= token_length_next;
      token_total <= token_total_next;
      line_position <= line_position_next;
    end
  end

endmodule
`default_nettype wire

[hdl/qts_result_buf.sv]
// Result register: holds the results of one word and hands them out one per cycle while result_ready is high.
// Depends on qts_pkg.
`default_nettype none
module qts_result_buf (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    load,
  input  qts_pkg::result_set_t   results,
  output logic                   free,
  output logic                   result_valid,
  input  wire                    result_ready,
  output qts_pkg::result_t       head
);
  import qts_pkg::*;

  result_set_t held;
  logic [1:0]  idx;

  assign head = held[idx];
  assign free = !result_valid || (result_ready && head.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx <= '0;
    end else if (result_valid && result_ready) begin
      if (head.last) begin
        result_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= results;
    end
  end

endmodule
`default_nettype wire

[hdl/quoted_token_splitter.sv]
// A word accepted into the input register is scanned from there; its results are loaded into
// the result register, which presents them one at a time. Throughput: one word per cycle while
// each word yields at most one result and result_ready is high; a word with more results holds
// the single result port until all are taken, which sets the rate on token ends and line ends.
// Reset (synchronous, active high) empties the input and result registers and starts a
// new line with no tokens.
`default_nettype none
module quoted_token_splitter #(
  parameter int MAX_TOKENS    = 16,
  parameter int MAX_TOKEN_LEN = 32,
  parameter int MAX_LINE_LEN  = 256
) (
  input  wire        clk,
  input  wire        rst,
  input  wire  [7:0] char_value,
  input  wire        char_valid,
  output logic       char_ready,
  output logic [1:0] kind,
  output logic [7:0] out_char,
  output logic [4:0] token_number,
  output logic       last,
  output logic       result_valid,
  input  wire        result_ready
);
  import qts_pkg::*;

  logic          in_valid;
  logic [7:0]    in_char;
  logic          step_fire;
  logic          buf_free;
  result_set_t   results;
  result_count_t count;
  result_t       head;

  assign step_fire = in_valid && ((count == 2'd0) || buf_free);
  assign char_ready = !in_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_ready) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      in_char <= char_value;
    end
  end

  qts_step #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .MAX_LINE_LEN  (MAX_LINE_LEN)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .char_value (in_char),
    .fire       (step_fire),
    .results    (results),
    .count      (count)
  );

  qts_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (step_fire && (count != 2'd0)),
    .results      (results),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  assign kind = head.kind;
  assign out_char = head.ch;
  assign token_number = head.num;
  assign last = head.last;

endmodule
`default_nettype wire

[test/quoted_token_splitter_tb.sv]
// Self-checking testbench for quoted_token_splitter: a directed table, a long line, then random lines.
// A behavioral tokenizer in this file predicts every result the table does not give; it depends only on qts_pkg.
`timescale 1ns / 100ps
module quoted_token_splitter_tb;
  import qts_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int TOKENS_MAX    = 16;
  localparam int TOKEN_LEN_MAX = 32;
  localparam int LINE_LEN_MAX  = 256;
  localparam int RANDOM_CHARS  = 50;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_PLAIN, SCAN_QUOTE, SCAN_DRAIN} scan_mode_t;

  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    result_t    res;
  } char_row_t;

  localparam result_t NO_RESULT      = '0;
  localparam result_t LINE_END_EMPTY = '{KIND_LINE_END, 8'd0, 5'd0, 1'b1};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_value = 8'd0;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [4:0] token_number;
  logic       last;
  logic       result_valid;
  logic       result_ready = 1'b0;

  scan_mode_t scan;
  logic [5:0] tok_len;
  logic [4:0] tok_count;
  logic [8:0] line_pos;
  result_t    step_out[$];
  result_t    token_results_q[$];

  bit calm = 1'b0;
  int rx_hold = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int line_ends = 0;
  int full_splits = 0;
  int count_limits = 0;
  int length_limits = 0;

  char_row_t dir_rows [25];

  quoted_token_splitter #(
    .MAX_TOKENS(TOKENS_MAX),
    .MAX_TOKEN_LEN(TOKEN_LEN_MAX),
    .MAX_LINE_LEN(LINE_LEN_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .char_value(char_value),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .kind(kind),
    .out_char(out_char),
    .token_number(token_number),
    .last(last),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void start_line();
    scan = SCAN_IDLE;
    tok_len = '0;
    tok_count = '0;
    line_pos = '0;
  endfunction

  function automatic void put_result(logic [1:0] k, logic [7:0] c, logic [4:0] num);
    result_t r;
    r.kind = k;
    r.ch = c;
    r.num = num;
    r.last = 1'b0;
    step_out.push_back(r);
    if (k == KIND_LINE_END) line_ends++;
  endfunction

  function automatic void close_token();
    put_result(KIND_TOKEN_END, 8'd0, tok_count);
    tok_count = tok_count + 5'd1;
    tok_len = '0;
    scan = SCAN_IDLE;
  endfunction

  function automatic void keep_char(logic [7:0] c);
    put_result(KIND_CHAR, c, tok_count);
    tok_len = tok_len + 6'd1;
    if (tok_len >= TOKEN_LEN_MAX - 1) begin
      full_splits++;
      close_token();
    end
  endfunction

  function automatic void tokenize_char(logic [7:0] c);
    bit term;
    bit sep;
    step_out.delete();
    term = (c == CHAR_NEWLINE) || (c == CHAR_NUL);
    sep = (c == CHAR_SPACE) || (c == CHAR_TAB);
    if (scan == SCAN_DRAIN) begin
      if (term) start_line();
    end else if (term) begin
      if (scan != SCAN_IDLE) close_token();
      put_result(KIND_LINE_END, 8'd0, tok_count);
      start_line();
    end else begin
      line_pos = line_pos + 9'd1;
      case (scan)
        SCAN_IDLE: begin
          if (!sep) begin
            scan = (c == CHAR_QUOTE) ? SCAN_QUOTE : SCAN_PLAIN;
            keep_char(c);
          end
        end
        SCAN_PLAIN: begin
          if (sep) close_token();
          else keep_char(c);
        end
        default: begin
          if (c == CHAR_QUOTE) begin
            keep_char(c);
            if (scan == SCAN_QUOTE) close_token();
          end else if (c == CHAR_TAB) begin
            close_token();
          end else begin
            keep_char(c);
          end
        end
      endcase
      if (tok_count >= TOKENS_MAX || line_pos >= LINE_LEN_MAX - 1) begin
        if (tok_count >= TOKENS_MAX) count_limits++;
        else length_limits++;
        if (scan != SCAN_IDLE) close_token();
        put_result(KIND_LINE_END, 8'd0, tok_count);
        start_line();
        scan = SCAN_DRAIN;
      end
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte(bit space_ok, bit quote_ok);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CHAR_NUL || b == CHAR_NEWLINE || b == CHAR_TAB ||
               (!space_ok && b == CHAR_SPACE) || (!quote_ok && b == CHAR_QUOTE));
    return b;
  endfunction

  function automatic logic [7:0] pick_sep();
    return ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  function automatic logic [7:0] pick_term();
    return ($urandom_range(0, 3) == 0) ? CHAR_NUL : CHAR_NEWLINE;
  endfunction

  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input result_t typed_res = NO_RESULT);
    int gap;
    char_value <= c;
    char_valid <= 1'b1;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    chars_sent++;
    tokenize_char(c);
    if (typed) token_results_q.push_back(typed_res);
    else foreach (step_out[i]) token_results_q.push_back(step_out[i]);
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    while (token_results_q.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (token_results_q.size() == 0) begin
        $display("%0t: result expected none, got kind %0d char %0d number %0d last %0d",
                 $time, kind, out_char, token_number, last);
        fail_count++;
      end else begin
        want = token_results_q.pop_front();
        results_seen++;
        check_field("kind", want.kind, kind);
        check_field("out_char", want.ch, out_char);
        check_field("token_number", want.num, token_number);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin : result_pacing
    int n;
    if (rst) begin
      result_ready <= 1'b0;
      rx_hold <= 0;
    end else if (result_valid && result_ready) begin
      n = calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        result_ready <= 1'b0;
        rx_hold <= n;
      end
    end else if (!result_ready) begin
      if (rx_hold <= 1) result_ready <= 1'b1;
      rx_hold <= (rx_hold > 0) ? rx_hold - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int rand_base;
    int style;
    int len;
    start_line();
    dir_rows = '{
      '{CHAR_NEWLINE, 1'b1, LINE_END_EMPTY},
      '{CHAR_NUL,     1'b1, LINE_END_EMPTY},
      '{CHAR_SPACE,   1'b0, NO_RESULT},
      '{CHAR_TAB,     1'b0, NO_RESULT},
      '{CHAR_NEWLINE, 1'b1, LINE_END_EMPTY},
      '{"a",          1'b1, '{KIND_CHAR, "a", 5'd0, 1'b1}},
      '{8'hFF,        1'b1, '{KIND_CHAR, 8'hFF, 5'd0, 1'b1}},
      '{CHAR_QUOTE,   1'b0, NO_RESULT},
      '{CHAR_SPACE,   1'b0, NO_RESULT},
      '{CHAR_QUOTE,   1'b0, NO_RESULT},
      '{"x",          1'b0, NO_RESULT},
      '{CHAR_SPACE,   1'b0, NO_RESULT},
      '{CHAR_QUOTE,   1'b0, NO_RESULT},
      '{8'h01,        1'b0, NO_RESULT},
      '{CHAR_TAB,     1'b0, NO_RESULT},
      '{CHAR_QUOTE,   1'b0, NO_RESULT},
      '{"q",          1'b0, NO_RESULT},
      '{CHAR_TAB,     1'b0, NO_RESULT},
      '{CHAR_QUOTE,   1'b0, NO_RESULT},
      '{"z",          1'b0, NO_RESULT},
      '{CHAR_NEWLINE, 1'b0, NO_RESULT},
      '{8'h80,        1'b0, NO_RESULT},
      '{8'h7F,        1'b0, NO_RESULT},
      '{CHAR_NUL,     1'b0, NO_RESULT},
      '{CHAR_NEWLINE, 1'b1, LINE_END_EMPTY}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_char(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].res);
    wait_for_results();

    // Long line: seven 20-character tokens between separator runs, so the length
    // limit cuts into an open token; the tail is dropped up to the newline.
    for (int i = 0; i < 262; i++) begin
      if (i % 40 < 20) send_char(pick_byte(1'b0, 1'b0));
      else send_char(pick_sep());
    end
    send_char(CHAR_NEWLINE);

    rand_base = chars_sent;
    while (chars_sent - rand_base < RANDOM_CHARS) begin
      calm <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) wait_for_results();
      style = $urandom_range(0, 7);
      if (style <= 4) begin
        repeat ($urandom_range(0, 2)) send_char(pick_sep());
        len = $urandom_range(1, 6);
        for (int t = 0; t < len; t++) begin
          if (t > 0) repeat ($urandom_range(1, 3)) send_char(pick_sep());
          if ($urandom_range(0, 2) == 0) begin
            send_char(CHAR_QUOTE);
            repeat ($urandom_range(0, 6)) send_char(pick_byte(1'b1, 1'b0));
            send_char(($urandom_range(0, 3) == 0) ? CHAR_TAB : CHAR_QUOTE);
          end else begin
            send_char(pick_byte(1'b0, 1'b0));
            repeat ($urandom_range(0, 7)) send_char(pick_byte(1'b0, 1'b1));
          end
        end
        if ($urandom_range(0, 1) == 1) send_char(pick_sep());
        send_char(pick_term());
      end else if (style == 5) begin
        if ($urandom_range(0, 1) == 0) begin
          send_char(CHAR_QUOTE);
          repeat ($urandom_range(25, 40)) send_char(pick_byte(1'b1, 1'b0));
        end else begin
          len = ($urandom_range(0, 1) == 0) ? TOKEN_LEN_MAX - 1 : $urandom_range(25, 45);
          send_char(pick_byte(1'b0, 1'b0));
          repeat (len - 1) send_char(pick_byte(1'b0, 1'b1));
        end
        if ($urandom_range(0, 1) == 1) send_char(CHAR_QUOTE);
        send_char(pick_term());
      end else if (style == 6) begin
        repeat ($urandom_range(TOKENS_MAX - 1, TOKENS_MAX + 2)) begin
          send_char(pick_byte(1'b0, 1'b0));
          if ($urandom_range(0, 1) == 1) send_char(pick_byte(1'b0, 1'b1));
          send_char(CHAR_SPACE);
        end
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)));
        send_char(CHAR_NEWLINE);
      end else begin
        repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
        send_char(CHAR_NEWLINE);
      end
    end
    char_valid <= 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters; %0d results compared, %0d line ends.",
             chars_sent, results_seen, line_ends);
    $display("Lines cut by token count: %0d, by line length: %0d; full-token splits: %0d.",
             count_limits, length_limits, full_splits);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/qts_pkg.sv
hdl/qts_step.sv
hdl/qts_result_buf.sv
hdl/quoted_token_splitter.sv
test/quoted_token_splitter_tb.sv
